// ===== src/quote_aware_section_splitter_macros.svh =====
// assertion macros shared by the splitter checker
// each macro expands to one labeled concurrent assertion clocked on clk, reset by rst
`ifndef QUOTE_AWARE_SECTION_SPLITTER_MACROS_SVH
`define QUOTE_AWARE_SECTION_SPLITTER_MACROS_SVH

// same-cycle implication
`define QASS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("splitter check failed");

// next-cycle implication
`define QASS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("splitter check failed");

`endif

// ===== src/qass_pkg.sv =====
// types and constants of the quote-aware section splitter
// used by the output buffer, the top level and the checker
package qass_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SECTION,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_SINGLE,
    Q_DOUBLE
  } quote_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       closed;
    logic       last;
  } result_t;

  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;

  localparam logic REG_SPLIT_BYTES = 1'b0;
  localparam logic REG_SPLIT_LEN   = 1'b1;

  localparam logic [63:0] SPLIT_BYTES_RESET = 64'd11565;
  localparam logic [3:0]  SPLIT_LEN_RESET   = 4'd2;

endpackage

// ===== src/qass_cell.sv =====
// one look-ahead cell: holds one window byte, compares it with its splitter byte
// and takes the byte shifted down from a later cell; depends on nothing but itself
module qass_cell #(
  parameter int N   = 8,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [7:0]                    load_byte,
  input  logic [$clog2(N+1)-1:0]        fill_old,
  input  logic [$clog2(N+1)-1:0]        fill_pre,
  input  logic [$clog2(N+1)-1:0]        len,
  input  logic [7:0]                    spl_byte,
  input  logic                          match_in,
  input  logic                          shift_en,
  input  logic [$clog2(N+1)-1:0]        shamt,
  input  logic [N-1:0][7:0]             pre_all,
  output logic [7:0]                    pre_byte,
  output logic                          match_out
);

  localparam int FILL_W = $clog2(N+1);
  localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

  logic [7:0]      held;
  logic            loaded;
  logic            hit;
  logic [FILL_W:0] src;
  logic [7:0]      shifted;

  always_comb begin
    loaded    = load && (fill_old == MY_IDX);
    pre_byte  = loaded ? load_byte : held;
    // positions past the splitter length always agree
    hit       = (MY_IDX >= len) || ((MY_IDX < fill_pre) && (pre_byte == spl_byte));
    match_out = match_in && hit;
    src       = {1'b0, MY_IDX} + {1'b0, shamt};
    shifted   = (src < (FILL_W+1)'(N)) ? pre_all[src[IDX_W-1:0]] : pre_byte;
  end

  always_ff @(posedge clk) begin
    held <= shift_en ? shifted : pre_byte;
  end

endmodule

// ===== src/qass_out_fifo.sv =====
// two-entry result buffer between the splitter core and the output channel
// depends on qass_pkg for the result type
module qass_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qass_pkg::result_t push_item,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output qass_pkg::result_t head
);

  logic [1:0]        count;
  logic [1:0]        count_next;
  qass_pkg::result_t slot1;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign room      = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_item;
      end else begin
        slot1 <= push_item;
      end
    end else if (pop && !push) begin
      head <= slot1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_item;
      end else begin
        head  <= slot1;
        slot1 <= push_item;
      end
    end
  end

endmodule

// ===== src/quote_aware_section_splitter.sv =====
// Quote-aware section splitter, top level.
// Input channel (in_valid/in_ready) carries one command line byte per transfer with
// byte_present and end_of_line; the output channel (out_valid/out_ready) carries one
// result per transfer: a section character, a new-section mark or the end-of-line
// result with quotes_closed. last_result marks the final result of an input item.
// The splitter string and its length are set over the APB port: splitter_bytes at
// address 0, splitter_length at address 8; change them only between items.
// A row of SPLIT_MAX cells holds the look-ahead window; the whole window compares
// against the splitter in the cycle a byte arrives, and a match outside quotes drops
// all of its bytes at once.
// Each transfer's first result is registered into the output buffer.
// An item with at most one result keeps in_ready high, so a byte per cycle flows
// while the buffer has room; an item with more results (up to SPLIT_MAX+1 on end of
// line) holds in_ready low, one result per cycle from the single decision step
// while room lasts. A two-entry output buffer keeps input transfers going while one
// result waits; when the receiver stalls and both entries are full, in_ready drops.
// Reset clears the window count, quote state and buffer and loads the default
// splitter (two bytes, "-" "-"); window bytes are not cleared.
module quote_aware_section_splitter #(
  parameter int SPLIT_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic        quotes_closed,
  output logic        last_result
);

  localparam int FILL_W = $clog2(SPLIT_MAX+1);

  // configuration registers
  logic [63:0] splitter_bytes;
  logic [3:0]  splitter_length;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      splitter_bytes  <= qass_pkg::SPLIT_BYTES_RESET;
      splitter_length <= qass_pkg::SPLIT_LEN_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == qass_pkg::REG_SPLIT_BYTES) begin
        splitter_bytes <= pwdata;
      end else begin
        splitter_length <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == qass_pkg::REG_SPLIT_LEN) begin
      prdata = {60'd0, splitter_length};
    end else begin
      prdata = splitter_bytes;
    end
  end

  // length clamped to 1..SPLIT_MAX
  logic [3:0]        len_c;
  logic [FILL_W-1:0] eff_len;

  always_comb begin
    if (splitter_length == 4'd0) begin
      len_c = 4'd1;
    end else if (splitter_length > 4'(SPLIT_MAX)) begin
      len_c = 4'(SPLIT_MAX);
    end else begin
      len_c = splitter_length;
    end
    eff_len = FILL_W'(len_c);
  end

  // control state
  qass_pkg::state_t  state;
  qass_pkg::state_t  state_next;
  qass_pkg::quote_t  quote;
  qass_pkg::quote_t  quote_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic                      room;
  logic                      accept;
  logic                      go;
  logic                      appended;
  logic [FILL_W-1:0]         fill_pre;
  logic                      flush;
  logic                      process;
  logic                      more;
  logic [FILL_W-1:0]         shamt;
  logic [SPLIT_MAX-1:0][7:0] pre_all;
  logic [SPLIT_MAX:0]        match_c;
  logic                      push;
  qass_pkg::result_t         res;
  qass_pkg::result_t         head;

  assign in_ready = room && (state == qass_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign match_c[0] = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < SPLIT_MAX; gi++) begin : g_cell
      qass_cell #(
        .N   (SPLIT_MAX),
        .IDX (gi)
      ) u_cell (
        .clk       (clk),
        .load      (appended),
        .load_byte (data_byte),
        .fill_old  (fill),
        .fill_pre  (fill_pre),
        .len       (eff_len),
        .spl_byte  (splitter_bytes[8*gi +: 8]),
        .match_in  (match_c[gi]),
        .shift_en  (process),
        .shamt     (shamt),
        .pre_all   (pre_all),
        .pre_byte  (pre_all[gi]),
        .match_out (match_c[gi+1])
      );
    end
  endgenerate

  always_comb begin
    go         = accept || ((state != qass_pkg::ST_IDLE) && room);
    appended   = accept && byte_present && (fill < FILL_W'(SPLIT_MAX));
    fill_pre   = fill + FILL_W'(appended);
    flush      = (state == qass_pkg::ST_FLUSH) || (accept && end_of_line);
    process    = go && (fill_pre != '0) && ((fill_pre >= eff_len) || flush);
    shamt      = FILL_W'(1);
    more       = 1'b0;
    push       = 1'b0;
    res.kind   = qass_pkg::KIND_CHAR;
    res.data   = 8'd0;
    res.closed = 1'b0;
    res.last   = 1'b0;
    quote_next = quote;
    fill_next  = fill;
    state_next = state;
    if (process) begin
      push     = 1'b1;
      res.data = pre_all[0];
      case (pre_all[0])
        qass_pkg::CHAR_SQUOTE: begin
          if (quote == qass_pkg::Q_NONE) begin
            quote_next = qass_pkg::Q_SINGLE;
          end else if (quote == qass_pkg::Q_SINGLE) begin
            quote_next = qass_pkg::Q_NONE;
          end
        end
        qass_pkg::CHAR_DQUOTE: begin
          if (quote == qass_pkg::Q_NONE) begin
            quote_next = qass_pkg::Q_DOUBLE;
          end else if (quote == qass_pkg::Q_DOUBLE) begin
            quote_next = qass_pkg::Q_NONE;
          end
        end
        default: begin
          // whole splitter held in the window: drop it in one shift
          if ((quote == qass_pkg::Q_NONE) && match_c[SPLIT_MAX]) begin
            res.kind = qass_pkg::KIND_SECTION;
            res.data = 8'd0;
            shamt    = eff_len;
          end
        end
      endcase
      fill_next = fill_pre - shamt;
      more      = flush || ((fill_next != '0) && (fill_next >= eff_len));
      res.last  = !more;
      if (!more) begin
        state_next = qass_pkg::ST_IDLE;
      end else if (flush) begin
        state_next = qass_pkg::ST_FLUSH;
      end else begin
        state_next = qass_pkg::ST_DRAIN;
      end
    end else if (go && flush) begin
      push       = 1'b1;
      res.kind   = qass_pkg::KIND_END;
      res.closed = (quote == qass_pkg::Q_NONE);
      res.last   = 1'b1;
      fill_next  = '0;
      quote_next = qass_pkg::Q_NONE;
      state_next = qass_pkg::ST_IDLE;
    end else if (go) begin
      fill_next  = fill_pre;
      state_next = qass_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qass_pkg::ST_IDLE;
      quote <= qass_pkg::Q_NONE;
      fill  <= '0;
    end else begin
      state <= state_next;
      quote <= quote_next;
      fill  <= fill_next;
    end
  end

  qass_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind   = head.kind;
  assign out_byte      = head.data;
  assign quotes_closed = head.closed;
  assign last_result   = head.last;

endmodule

// ===== src/qass_checker.sv =====
// port-level checks on the splitter's result channel, bound to the top level
// depends on qass_pkg and the shared assertion macros
`include "quote_aware_section_splitter_macros.svh"

module qass_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic [7:0] out_byte,
  input logic       quotes_closed,
  input logic       last_result
);

  // stalled transfer keeps its result kind, byte and last flag
  `QASS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(out_byte) && $stable(last_result))

  // marks carry no character
  `QASS_ASSERT_NOW(a_mark_no_byte, out_valid && (result_kind != qass_pkg::KIND_CHAR), out_byte == 8'd0)

  // end of line always closes the item's results
  `QASS_ASSERT_NOW(a_end_is_last, out_valid && (result_kind == qass_pkg::KIND_END), last_result)

  // quote status only reported on the end result
  `QASS_ASSERT_NOW(a_closed_on_end, out_valid && (result_kind != qass_pkg::KIND_END), !quotes_closed)

endmodule

bind quote_aware_section_splitter qass_checker u_qass_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_kind   (result_kind),
  .out_byte      (out_byte),
  .quotes_closed (quotes_closed),
  .last_result   (last_result)
);
